@@ rtl/trigger_hold_inject_sequencer_macros.svh @@
// Assertion macros for the trigger hold and inject sequencer.
// Needs signals named clock and reset in the including scope.
`ifndef TRIGGER_HOLD_INJECT_SEQUENCER_MACROS_SVH
`define TRIGGER_HOLD_INJECT_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define THI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define THI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/thi_pkg.sv @@
// Package for the trigger hold and inject sequencer: codes, reset values, helpers.
// No dependencies.
package thi_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int THR_BITS        = 10;
   localparam int CNT_BITS        = 8;
   localparam int CSR_IDX_BITS    = 3;
   localparam int CSR_DATA_BITS   = 10;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_STOP   = 3'd1,
      ACT_LOW    = 3'd2,
      ACT_HIGH   = 3'd3,
      ACT_INJECT = 3'd4,
      ACT_BEEP   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      CHG_UNKNOWN  = 2'd0,
      CHG_OFF      = 2'd1,
      CHG_CHARGING = 2'd2,
      CHG_CHARGED  = 2'd3
   } charge_type;

   localparam logic [CSR_IDX_BITS-1:0] REG_DEBOUNCE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LOW_THR  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_HIGH_THR = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BEEP     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAP      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_REPEAT   = 3'd5;

   localparam logic [CNT_BITS-1:0] DEBOUNCE_RST = 8'd5;
   localparam logic [THR_BITS-1:0] LOW_THR_RST  = 10'd802;
   localparam logic [THR_BITS-1:0] HIGH_THR_RST = 10'd1013;
   localparam logic [CNT_BITS-1:0] BEEP_RST     = 8'd5;
   localparam logic [CNT_BITS-1:0] GAP_RST      = 8'd40;
   localparam logic [1:0]          REPEAT_RST   = 2'd3;

   localparam logic [CNT_BITS-1:0] GREEN_BASE = 8'd50;

   // saturating 8 bit increment
   function automatic logic [CNT_BITS-1:0] bump8(input logic [CNT_BITS-1:0] v);
      bump8 = (v == {CNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   // 50 + 100 * repeat, kept to 8 bits
   function automatic logic [CNT_BITS-1:0] green_of(input logic [1:0] rpt);
      unique case (rpt)
         2'd0:    green_of = 8'd50;
         2'd1:    green_of = 8'd150;
         2'd2:    green_of = 8'd250;
         default: green_of = 8'd94;
      endcase
   endfunction

endpackage

@@ rtl/trigger_hold_inject_sequencer.sv @@
// Trigger hold and inject sequencer: debounce, classify, beep series, charger tracking.
// Depends on thi_pkg and trigger_hold_inject_sequencer_macros.svh.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | trigger, select, probe sample, charger pins
//  rsp     | out | rsp_tvalid/rsp_tready  | action, green level, charge event
//  csr     | in  | csr_we                 | csr_index, csr_wdata
//
// One request per cycle unless stalled; each request gives one response in the
// following cycle. All state updates in the accepting cycle; the response sits in one
// output register. req_tready drops only while that register is full and stalled.
// Synchronous active-high reset clears state and loads register defaults.
module trigger_hold_inject_sequencer
   import thi_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] trigger_level, [1] select_level, [SAMPLE_BITS+1:2] probe_sample,
   // [SAMPLE_BITS+2] charger_connected, [SAMPLE_BITS+3] charge_done, rest zero
   input  logic [((SAMPLE_BITS+4+7)/8)*8-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] action, [10:3] green_level, [12:11] charge_event, [15:13] zero
   output logic [15:0]                      rsp_tdata,
   input  logic                             csr_we,
   input  logic [CSR_IDX_BITS-1:0]          csr_index,
   input  logic [CSR_DATA_BITS-1:0]         csr_wdata
);

   localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

   // configuration
   logic [CNT_BITS-1:0] debounce_ff, beep_ticks_ff, gap_ticks_ff;
   logic [THR_BITS-1:0] low_thr_ff, high_thr_ff;
   logic [1:0]          repeat_limit_ff;

   // state
   logic                seen_ff, seen_in;
   logic [CNT_BITS-1:0] stable_ff, stable_in;
   logic                settled_ff, settled_in;
   logic                holding_ff, holding_in;
   logic                done_ff, done_in;
   logic                beeping_ff, beeping_in;
   logic [CNT_BITS-1:0] tick_ff, tick_in;
   logic [1:0]          repeat_ff, repeat_in;
   charge_type          charge_ff, charge_in;

   // response register
   logic                rsp_valid_ff;
   action_type          action_ff, action_in;
   logic [CNT_BITS-1:0] green_ff, green_in;
   charge_type          event_ff, event_in;

   logic                   accept;
   logic                   trig, sel, conn, full;
   logic [SAMPLE_BITS-1:0] sample;
   logic [CMP_W-1:0]       sample_x, low_x, high_x;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign trig   = req_tdata[0];
   assign sel    = req_tdata[1];
   assign sample = req_tdata[SAMPLE_BITS+1:2];
   assign conn   = req_tdata[SAMPLE_BITS+2];
   assign full   = req_tdata[SAMPLE_BITS+3];

   assign sample_x = CMP_W'(sample);
   assign low_x    = CMP_W'(low_thr_ff);
   assign high_x   = CMP_W'(high_thr_ff);

   always_comb begin
      charge_type          target;
      logic                first_set;
      action_type          act2;
      logic [CNT_BITS-1:0] green2, tick_b;
      logic [1:0]          rpt_b;

      // charger tracking
      target    = conn ? (full ? CHG_CHARGED : CHG_CHARGING) : CHG_OFF;
      charge_in = target;
      event_in  = (charge_ff != target) ? target : CHG_UNKNOWN;

      // trigger debounce
      if (trig == seen_ff) begin
         seen_in    = seen_ff;
         stable_in  = bump8(stable_ff);
         settled_in = settled_ff || (stable_in >= debounce_ff);
      end else begin
         seen_in    = trig;
         stable_in  = '0;
         settled_in = 1'b0;
      end

      action_in  = ACT_NONE;
      green_in   = '0;
      first_set  = 1'b0;
      holding_in = holding_ff;
      done_in    = done_ff;
      beeping_in = beeping_ff;
      tick_in    = tick_ff;
      repeat_in  = repeat_ff;

      if (settled_in) begin
         if (seen_in) begin
            // settled release
            if (beeping_ff) begin
               action_in  = ACT_STOP;
               first_set  = 1'b1;
               beeping_in = 1'b0;
            end
            holding_in = 1'b0;
            done_in    = 1'b0;
         end else if (!holding_ff) begin
            holding_in = 1'b1;
            first_set  = 1'b1;
            priority if (sample_x < low_x) begin
               action_in = ACT_LOW;
               done_in   = 1'b1;
            end else if (sample_x > high_x) begin
               action_in = ACT_HIGH;
               done_in   = 1'b1;
            end else if (sel) begin
               action_in = ACT_INJECT;
               done_in   = 1'b1;
            end else begin
               action_in  = ACT_BEEP;
               green_in   = GREEN_BASE;
               beeping_in = 1'b1;
               repeat_in  = '0;
               tick_in    = '0;
            end
         end
      end

      // beep series timing
      act2   = ACT_NONE;
      green2 = '0;
      tick_b = bump8(tick_in);
      rpt_b  = repeat_in + 2'd1;
      if (holding_in && !done_in) begin
         tick_in = tick_b;
         if (beeping_in) begin
            if (tick_b >= beep_ticks_ff) begin
               act2       = ACT_STOP;
               beeping_in = 1'b0;
               tick_in    = '0;
            end
         end else if (tick_b >= gap_ticks_ff) begin
            repeat_in = rpt_b;
            if (rpt_b >= repeat_limit_ff) begin
               act2    = ACT_INJECT;
               done_in = 1'b1;
            end else begin
               act2       = ACT_BEEP;
               green2     = green_of(rpt_b);
               beeping_in = 1'b1;
               tick_in    = '0;
            end
         end
      end
      if (!first_set && act2 != ACT_NONE) begin
         action_in = act2;
         green_in  = green2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RST;
         low_thr_ff      <= LOW_THR_RST;
         high_thr_ff     <= HIGH_THR_RST;
         beep_ticks_ff   <= BEEP_RST;
         gap_ticks_ff    <= GAP_RST;
         repeat_limit_ff <= REPEAT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE: debounce_ff     <= csr_wdata[CNT_BITS-1:0];
            REG_LOW_THR:  low_thr_ff      <= csr_wdata[THR_BITS-1:0];
            REG_HIGH_THR: high_thr_ff     <= csr_wdata[THR_BITS-1:0];
            REG_BEEP:     beep_ticks_ff   <= csr_wdata[CNT_BITS-1:0];
            REG_GAP:      gap_ticks_ff    <= csr_wdata[CNT_BITS-1:0];
            REG_REPEAT:   repeat_limit_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         stable_ff    <= '0;
         settled_ff   <= 1'b0;
         holding_ff   <= 1'b0;
         done_ff      <= 1'b0;
         beeping_ff   <= 1'b0;
         tick_ff      <= '0;
         repeat_ff    <= '0;
         charge_ff    <= CHG_UNKNOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            seen_ff    <= seen_in;
            stable_ff  <= stable_in;
            settled_ff <= settled_in;
            holding_ff <= holding_in;
            done_ff    <= done_in;
            beeping_ff <= beeping_in;
            tick_ff    <= tick_in;
            repeat_ff  <= repeat_in;
            charge_ff  <= charge_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= action_in;
         green_ff  <= green_in;
         event_ff  <= event_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, event_ff, green_ff, action_ff};

`include "trigger_hold_inject_sequencer_macros.svh"

   `THI_ASSERT_NOW(a_beep_needs_hold, beeping_ff, holding_ff && !done_ff, "beep without open hold")
   `THI_ASSERT_NOW(a_stall_blocks_req, rsp_valid_ff && !rsp_tready, !req_tready, "request taken over stalled response")
   `THI_ASSERT_NEXT(a_charge_known, accept, charge_ff != CHG_UNKNOWN, "charger state unknown after request")
   `THI_ASSERT_NEXT(a_accept_fills_rsp, accept, rsp_valid_ff, "accepted request gave no response")

endmodule
